### rtl/core/header_checksum_frame_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the header checksum frame receiver
// Clocked property checks that are compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HEADER_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define HEADER_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every edge outside reset.
`define HCFR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hcfr: property check failed");
// A condition that must be followed by a given state in the next cycle.
`define HCFR_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("hcfr: sequence check failed");
`else
`define HCFR_ASSERT(label, clk, rst, prop)
`define HCFR_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

### rtl/core/hcfr_pkg.sv
// ----------------------------------------------------------------------------
// hcfr_pkg
// Shared constants, types and helpers of the header checksum frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package hcfr_pkg;

   localparam int MAX_PAYLOAD = 61;
   localparam int RING_DEPTH  = MAX_PAYLOAD + 3;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_FIRST_HDR   = 2'd0,
      CSR_SECOND_HDR  = 2'd1,
      CSR_PAYLOAD_LEN = 2'd2
   } csr_index_type;

   // Command from the controller to the row of cells.
   typedef struct packed {
      logic              shift;
      logic [BYTE_W-1:0] insert;
      logic [IDX_W-1:0]  tail;
   } ring_ctl_type;

   // The three fixed taps at the head of the row.
   typedef struct packed {
      logic [BYTE_W-1:0] head0;
      logic [BYTE_W-1:0] head1;
      logic [BYTE_W-1:0] head2;
   } ring_taps_type;

   // Clamp the programmed payload length into 1 .. MAX_PAYLOAD.
   function automatic logic [IDX_W-1:0] eff_payload(input logic [IDX_W-1:0] raw);
      logic [IDX_W-1:0] p;
      p = raw;
      if (raw == '0) begin
         p = IDX_W'(1);
      end else if (raw > IDX_W'(MAX_PAYLOAD)) begin
         p = IDX_W'(MAX_PAYLOAD);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

### rtl/core/hcfr_cell.sv
// ----------------------------------------------------------------------------
// hcfr_cell
// One byte of the receive window; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hcfr_cell (
   input  wire logic                         clock,
   input  wire logic                         shift_en,
   input  wire logic                         active,
   input  wire logic                         is_tail,
   input  wire logic [hcfr_pkg::BYTE_W-1:0]  next_byte,
   input  wire logic [hcfr_pkg::BYTE_W-1:0]  insert_byte,
   output logic      [hcfr_pkg::BYTE_W-1:0]  data_o
);

   logic [hcfr_pkg::BYTE_W-1:0] data_ff;
   logic [hcfr_pkg::BYTE_W-1:0] data_in;

   // The tail cell closes the ring (or takes a fresh byte); other active cells shift down.
   always_comb begin
      data_in = data_ff;
      if (shift_en && active) begin
         data_in = is_tail ? insert_byte : next_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_o = data_ff;

endmodule

`default_nettype wire

### rtl/core/hcfr_ring.sv
// ----------------------------------------------------------------------------
// hcfr_ring
// Row of byte cells forming the rotating receive window.
// ----------------------------------------------------------------------------
`default_nettype none

module hcfr_ring (
   input  wire logic                  clock,
   input  wire hcfr_pkg::ring_ctl_type ctl,
   output hcfr_pkg::ring_taps_type     taps
);

   logic [hcfr_pkg::BYTE_W-1:0] cell_q [hcfr_pkg::RING_DEPTH];

   for (genvar k = 0; k < hcfr_pkg::RING_DEPTH; k++) begin : g_cell
      localparam logic [hcfr_pkg::IDX_W-1:0] CellIdx = hcfr_pkg::IDX_W'(k);
      logic [hcfr_pkg::BYTE_W-1:0] next_byte;

      if (k == hcfr_pkg::RING_DEPTH - 1) begin : g_end
         assign next_byte = '0;
      end else begin : g_mid
         assign next_byte = cell_q[k+1];
      end

      hcfr_cell u_cell (
         .clock       (clock),
         .shift_en    (ctl.shift),
         .active      (CellIdx <= ctl.tail),
         .is_tail     (CellIdx == ctl.tail),
         .next_byte   (next_byte),
         .insert_byte (ctl.insert),
         .data_o      (cell_q[k])
      );
   end

   assign taps.head0 = cell_q[0];
   assign taps.head1 = cell_q[1];
   assign taps.head2 = cell_q[2];

endmodule

`default_nettype wire

### rtl/core/header_checksum_frame_receiver_top.sv
// An item that does not complete a window is absorbed and the block stays
// idle. An item that completes a window starts a scan of up to W = payload_len + 3
// rotations, one rotation of the cell row per cycle; a match then rotates the row
// to align the frame, emits payload_len bytes (plus any output stall) and rotates
// the row back to its idle alignment before the next item is taken.
// Reset (synchronous, active high) restores the registers to 0xFF, 0xFE, 8.
// ----------------------------------------------------------------------------
// header_checksum_frame_receiver_top
// Finds two-byte-header frames with a sum-8 checksum in a byte stream and
// emits their payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "header_checksum_frame_receiver_top_assert.svh"

module header_checksum_frame_receiver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items: tdata[7:0] = rx_byte.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // Result items: tdata[7:0] = payload_byte, tdata[13:8] = byte_index,
   // tdata[15:14] = zero; tlast = last_byte.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast,
   // Configuration writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   localparam int BW = hcfr_pkg::BYTE_W;
   localparam int IW = hcfr_pkg::IDX_W;
   localparam int CW = hcfr_pkg::COUNT_W;

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_SEEK    = 5'b00100,
      ST_EMIT    = 5'b01000,
      ST_RESTORE = 5'b10000
   } state_type;

   // The window lives in a row of cells whose head (cell 0) is always the
   // next write slot while idle. A write drops the new byte into the tail
   // cell W-1 and shifts the other window cells down by one, so the row rotates
   // with the write position. A scan rotates the row up to W times; at rotation r
   // the head holds window[wp + r], so the physical start index is (wp + r) mod W.
   // The checksum of a rotation is taken from a running sum of the whole
   // window minus the two header bytes and the checksum byte, so every
   // rotation is checked by combinational logic.

   state_type state_ff, state_in;

   logic [BW-1:0] first_hdr_ff, first_hdr_in;
   logic [BW-1:0] second_hdr_ff, second_hdr_in;
   logic [IW-1:0] plen_ff, plen_in;

   logic [IW-1:0] wp_ff, wp_in;          // physical index of the head cell
   logic [CW-1:0] fill_ff, fill_in;      // bytes written since restart, up to W
   logic [CW-1:0] count_ff, count_in;    // bytes since restart or last frame
   logic [BW-1:0] total_ff, total_in;    // sum-8 of the W window bytes
   logic [BW-1:0] prev_ff, prev_in;      // copy of the tail cell W-1
   logic [IW-1:0] rot_ff, rot_in;        // rotation relative to idle alignment
   logic [CW-1:0] bound_ff, bound_in;    // first rotation that wraps index 0
   logic          cand_vld_ff, cand_vld_in;
   logic [IW-1:0] cand_ff, cand_in;      // earliest match before the wrap
   logic [IW-1:0] emit_idx_ff, emit_idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_byte_ff, rsp_byte_in;
   logic [IW-1:0] rsp_idx_ff, rsp_idx_in;
   logic          rsp_last_ff, rsp_last_in;

   hcfr_pkg::ring_ctl_type  ring_ctl;
   hcfr_pkg::ring_taps_type taps;

   logic [IW-1:0] p_eff;
   logic [CW-1:0] w_eff;
   logic [IW-1:0] tail;
   logic          fill_full;
   logic          in_accept;
   logic          rotate;
   logic [IW-1:0] rot_next;
   logic [IW-1:0] wp_next;
   logic [CW-1:0] count_next;
   logic [BW-1:0] sum_chk;
   logic          match;
   logic          past_wrap;
   logic          take_cand;
   logic          scan_cand_vld;
   logic [IW-1:0] scan_cand;
   logic          out_free;

   assign p_eff     = hcfr_pkg::eff_payload(plen_ff);
   assign w_eff     = CW'(p_eff) + CW'(3);
   assign tail      = p_eff + IW'(2);
   assign fill_full = (fill_ff == w_eff);

   assign req_tready = (state_ff == ST_IDLE);
   assign in_accept  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rot_next   = (rot_ff == tail) ? '0 : rot_ff + IW'(1);
   assign wp_next    = (wp_ff == tail) ? '0 : wp_ff + IW'(1);
   assign count_next = (count_ff == hcfr_pkg::COUNT_MAX) ? count_ff : count_ff + CW'(1);

   // Head cells give the two header bytes, prev_ff the checksum byte, and
   // the payload sum is whatever remains of the window total.
   assign sum_chk = total_ff - taps.head0 - taps.head1 - prev_ff;
   assign match   = (taps.head0 == first_hdr_ff) && (taps.head1 == second_hdr_ff) &&
                    (prev_ff == sum_chk);

   // Rotations at or past the wrap point start at a lower physical index
   // than any rotation before it, so a match there wins at once.
   assign past_wrap     = (CW'(rot_ff) >= bound_ff);
   assign take_cand     = match && !past_wrap && !cand_vld_ff;
   assign scan_cand_vld = cand_vld_ff || take_cand;
   assign scan_cand     = take_cand ? rot_ff : cand_ff;

   always_comb begin
      state_in      = state_ff;
      first_hdr_in  = first_hdr_ff;
      second_hdr_in = second_hdr_ff;
      plen_in       = plen_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      prev_in       = prev_ff;
      rot_in        = rot_ff;
      bound_in      = bound_ff;
      cand_vld_in   = cand_vld_ff;
      cand_in       = cand_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      rotate        = 1'b0;
      ring_ctl.shift  = 1'b0;
      ring_ctl.insert = taps.head0;
      ring_ctl.tail   = tail;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               ring_ctl.shift  = 1'b1;
               ring_ctl.insert = req_tdata;
               prev_in  = req_tdata;
               total_in = total_ff + req_tdata - (fill_full ? taps.head0 : '0);
               fill_in  = fill_full ? fill_ff : fill_ff + CW'(1);
               wp_in    = wp_next;
               count_in = count_next;
               if (count_next >= w_eff) begin
                  state_in    = ST_SCAN;
                  rot_in      = '0;
                  cand_vld_in = 1'b0;
                  bound_in    = w_eff - CW'(wp_next);
               end
            end
         end
         ST_SCAN: begin
            if (match && past_wrap) begin
               state_in    = ST_EMIT;
               emit_idx_in = '0;
               count_in    = '0;
            end else begin
               rotate      = 1'b1;
               cand_vld_in = scan_cand_vld;
               cand_in     = scan_cand;
               if (rot_ff == tail) begin
                  if (scan_cand_vld) begin
                     count_in    = '0;
                     emit_idx_in = '0;
                     state_in    = (scan_cand == '0) ? ST_EMIT : ST_SEEK;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_SEEK: begin
            rotate = 1'b1;
            if (rot_next == cand_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rotate       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = taps.head2;
               rsp_idx_in   = emit_idx_ff;
               rsp_last_in  = (emit_idx_ff == p_eff - IW'(1));
               emit_idx_in  = emit_idx_ff + IW'(1);
               if (emit_idx_ff == p_eff - IW'(1)) begin
                  state_in = ST_RESTORE;
               end
            end
         end
         ST_RESTORE: begin
            if (rot_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               rotate = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A plain rotation closes the ring: the head byte moves to the tail.
      if (rotate) begin
         ring_ctl.shift  = 1'b1;
         ring_ctl.insert = taps.head0;
         prev_in         = taps.head0;
         rot_in          = rot_next;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hcfr_pkg::CSR_FIRST_HDR:  first_hdr_in  = csr_data;
            hcfr_pkg::CSR_SECOND_HDR: second_hdr_in = csr_data;
            hcfr_pkg::CSR_PAYLOAD_LEN: begin
               // A new length restarts reception; the cell contents stay.
               plen_in  = csr_data[IW-1:0];
               wp_in    = '0;
               fill_in  = '0;
               count_in = '0;
               total_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_hdr_ff  <= 8'hFF;
         second_hdr_ff <= 8'hFE;
         plen_ff       <= IW'(8);
         wp_ff         <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         rot_ff        <= '0;
         cand_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_hdr_ff  <= first_hdr_in;
         second_hdr_ff <= second_hdr_in;
         plen_ff       <= plen_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         rot_ff        <= rot_in;
         cand_vld_ff   <= cand_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      bound_ff    <= bound_in;
      cand_ff     <= cand_in;
      emit_idx_ff <= emit_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   hcfr_ring u_ring (
      .clock (clock),
      .ctl   (ring_ctl),
      .taps  (taps)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The row must be back in its idle alignment whenever items are taken.
   `HCFR_ASSERT(a_idle_aligned, clock, reset, (state_ff == ST_IDLE) |-> (rot_ff == '0))
   // The running window sum never counts more bytes than the window holds.
   `HCFR_ASSERT(a_fill_bounded, clock, reset, fill_ff <= w_eff)
   // Committing to a frame clears the byte count.
   `HCFR_ASSERT_NEXT(a_frame_clears, clock, reset,
                     (state_ff == ST_SCAN) && (state_in == ST_EMIT), count_ff == '0)

endmodule

`default_nettype wire
